// File: rtl/bqc_pkg.sv
// Shared types, character constants and closer codes for the bracket quote closer.
`timescale 1ns / 1ps

package bqc_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] code_t;

    localparam byte_t CH_LPAREN    = 8'h28;
    localparam byte_t CH_RPAREN    = 8'h29;
    localparam byte_t CH_LBRACKET  = 8'h5B;
    localparam byte_t CH_RBRACKET  = 8'h5D;
    localparam byte_t CH_LBRACE    = 8'h7B;
    localparam byte_t CH_RBRACE    = 8'h7D;
    localparam byte_t CH_BACKSLASH = 8'h5C;
    localparam byte_t CH_BACKQUOTE = 8'h60;
    localparam byte_t CH_DQUOTE    = 8'h22;
    localparam byte_t CH_APOS      = 8'h27;
    localparam byte_t CH_NUL       = 8'h00;

    localparam code_t CODE_PAREN     = 3'd0;
    localparam code_t CODE_BRACKET   = 3'd1;
    localparam code_t CODE_BRACE     = 3'd2;
    localparam code_t CODE_DQUOTE    = 3'd3;
    localparam code_t CODE_BACKQUOTE = 3'd4;
    localparam code_t CODE_APOS      = 3'd5;

    typedef struct packed {
        logic take;
        logic pop;
        logic clear;
        logic load_echo;
        logic load_mark;
        logic load_pop;
    } dp_cmd_t;

    typedef struct packed {
        logic byte_zero;
        logic empty_after;
        logic lvl_last;
    } dp_status_t;

    function automatic byte_t closer_char(input code_t code);
        byte_t ch;
        unique case (code)
            CODE_PAREN:     ch = CH_RPAREN;
            CODE_BRACKET:   ch = CH_RBRACKET;
            CODE_BRACE:     ch = CH_RBRACE;
            CODE_DQUOTE:    ch = CH_DQUOTE;
            CODE_BACKQUOTE: ch = CH_BACKQUOTE;
            CODE_APOS:      ch = CH_APOS;
            default:        ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/bqc_ctrl.sv
// Controller: accepts bytes, sequences the closer unwind and owns the result valid.
`timescale 1ns / 1ps

module bqc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_is_final,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  bqc_pkg::dp_status_t  status,
    output bqc_pkg::dp_cmd_t     cmd
);
    import bqc_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_UNWIND
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        out_free     = !m_valid_reg || m_ready;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = (state_reg == ST_IDLE) && out_free;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.take = 1'b1;
                    if (!status.byte_zero) begin
                        cmd.load_echo = 1'b1;
                        m_valid_next  = 1'b1;
                    end
                    if (s_is_final) begin
                        if (!status.empty_after) begin
                            state_next = ST_UNWIND;
                        end else begin
                            cmd.clear = 1'b1;
                            if (status.byte_zero) begin
                                cmd.load_mark = 1'b1;
                                m_valid_next  = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_UNWIND: begin
                if (out_free) begin
                    cmd.pop      = 1'b1;
                    cmd.load_pop = 1'b1;
                    m_valid_next = 1'b1;
                    if (status.lvl_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: rtl/bqc_dp.sv
// Datapath: closer stack memory, string and escape flags, result payload registers.
`timescale 1ns / 1ps

module bqc_dp #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bqc_pkg::byte_t       s_char_in,
    input  logic                 s_is_final,
    input  bqc_pkg::dp_cmd_t     cmd,
    output bqc_pkg::dp_status_t  status,
    output bqc_pkg::byte_t       m_char_out,
    output logic                 m_end_of_run,
    output logic                 m_overflowed
);
    import bqc_pkg::*;

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    code_t            stack_mem [STACK_DEPTH];
    code_t            top_reg;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic [LVL_W-1:0] level_take;
    logic [LVL_W-1:0] lvl_dec;
    logic [AW-1:0]    rd_addr;
    logic             in_str_reg;
    logic             in_str_next;
    logic             in_str_take;
    logic             esc_reg;
    logic             esc_next;
    logic             esc_take;
    logic             ovf_reg;
    logic             ovf_next;
    logic             ovf_take;
    logic             take_push;
    code_t            push_code;
    byte_t            top_char;
    logic             full;
    logic             do_push;
    byte_t            char_out_reg;
    logic             end_reg;
    logic             ovf_out_reg;

    assign top_char = (level_reg == '0) ? CH_NUL : closer_char(top_reg);
    assign full     = (level_reg == LVL_W'(STACK_DEPTH));

    always_comb begin
        level_take  = level_reg;
        in_str_take = in_str_reg;
        esc_take    = esc_reg;
        ovf_take    = ovf_reg;
        take_push   = 1'b0;
        push_code   = CODE_PAREN;
        if (s_char_in != CH_NUL) begin
            if (in_str_reg) begin
                if (esc_reg) begin
                    esc_take = 1'b0;
                end else if (s_char_in == CH_BACKSLASH) begin
                    esc_take = 1'b1;
                end else if (s_char_in == top_char) begin
                    level_take  = level_reg - LVL_W'(1);
                    in_str_take = 1'b0;
                end
            end else if (level_reg != '0 && s_char_in == top_char) begin
                level_take = level_reg - LVL_W'(1);
            end else begin
                unique case (s_char_in)
                    CH_LPAREN:    begin take_push = 1'b1; push_code = CODE_PAREN;     end
                    CH_LBRACKET:  begin take_push = 1'b1; push_code = CODE_BRACKET;   end
                    CH_LBRACE:    begin take_push = 1'b1; push_code = CODE_BRACE;     end
                    CH_DQUOTE:    begin take_push = 1'b1; push_code = CODE_DQUOTE;    end
                    CH_BACKQUOTE: begin take_push = 1'b1; push_code = CODE_BACKQUOTE; end
                    CH_APOS:      begin take_push = 1'b1; push_code = CODE_APOS;      end
                    default:      take_push = 1'b0;
                endcase
                if (take_push) begin
                    if (full) begin
                        ovf_take = 1'b1;
                    end else begin
                        level_take = level_reg + LVL_W'(1);
                        if (push_code == CODE_DQUOTE || push_code == CODE_BACKQUOTE ||
                            push_code == CODE_APOS) begin
                            in_str_take = 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign do_push = cmd.take && take_push && !full;

    always_comb begin
        level_next  = level_reg;
        in_str_next = in_str_reg;
        esc_next    = esc_reg;
        ovf_next    = ovf_reg;
        if (cmd.pop) begin
            level_next = level_reg - LVL_W'(1);
        end else if (cmd.take) begin
            level_next  = level_take;
            in_str_next = in_str_take;
            esc_next    = esc_take;
            ovf_next    = ovf_take;
        end
        if (cmd.clear) begin
            level_next  = '0;
            in_str_next = 1'b0;
            esc_next    = 1'b0;
            ovf_next    = 1'b0;
        end
    end

    assign lvl_dec = level_next - LVL_W'(1);
    assign rd_addr = (level_next == '0) ? '0 : lvl_dec[AW-1:0];

    assign status.byte_zero   = (s_char_in == CH_NUL);
    assign status.empty_after = (level_take == '0);
    assign status.lvl_last    = (level_reg == LVL_W'(1));

    always_ff @(posedge aclk) begin
        if (do_push) begin
            stack_mem[level_reg[AW-1:0]] <= push_code;
            top_reg                      <= push_code;
        end else begin
            top_reg <= stack_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= '0;
            in_str_reg <= 1'b0;
            esc_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
        end else begin
            level_reg  <= level_next;
            in_str_reg <= in_str_next;
            esc_reg    <= esc_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_echo) begin
            char_out_reg <= s_char_in;
            end_reg      <= s_is_final && (level_take == '0);
            ovf_out_reg  <= ovf_take;
        end else if (cmd.load_mark) begin
            char_out_reg <= CH_NUL;
            end_reg      <= 1'b1;
            ovf_out_reg  <= ovf_reg;
        end else if (cmd.load_pop) begin
            char_out_reg <= top_char;
            end_reg      <= (level_reg == LVL_W'(1));
            ovf_out_reg  <= ovf_reg;
        end
    end

    assign m_char_out   = char_out_reg;
    assign m_end_of_run = end_reg;
    assign m_overflowed = ovf_out_reg;

`ifndef NO_ASSERTIONS
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LVL_W'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_string_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        in_str_reg |-> (level_reg != '0))
        else $error("string open with empty stack");

    a_escape_in_string: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> in_str_reg)
        else $error("escape pending outside a string");

    a_unwind_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_pop && level_reg == LVL_W'(1))
            |=> (level_reg == '0 && !in_str_reg && !ovf_reg && !esc_reg))
        else $error("state not cleared after last closer");
`endif

endmodule

// File: rtl/bracket_quote_closer.sv
// Top level of the bracket quote closer: controller plus datapath.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_char_in[7:0], s_is_final
//   m_      | out       | m_valid / m_ready  | m_char_out[7:0], m_end_of_run, m_overflowed
//
// One byte is taken per cycle while no unwind is in progress and the result register is free or being drained.
// A final byte with N pending closers is followed by N further results, one stack pop each,
// paced by the single read port of the closer stack memory.
// Reset (aresetn low, synchronous) empties the stack and clears all flags.
// A stalled m_ready holds the result register and stops input acceptance.
`timescale 1ns / 1ps

module bracket_quote_closer #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bqc_pkg::byte_t       s_char_in,
    input  logic                 s_is_final,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bqc_pkg::byte_t       m_char_out,
    output logic                 m_end_of_run,
    output logic                 m_overflowed
);
    import bqc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    bqc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_is_final (s_is_final),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .status     (status),
        .cmd        (cmd)
    );

    bqc_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_char_in    (s_char_in),
        .s_is_final   (s_is_final),
        .cmd          (cmd),
        .status       (status),
        .m_char_out   (m_char_out),
        .m_end_of_run (m_end_of_run),
        .m_overflowed (m_overflowed)
    );

endmodule

// File: test/bracket_quote_closer_checker.sv
// Channel monitor for the bracket quote closer: predicts each result and compares it.
`timescale 1ns / 1ps

module bracket_quote_closer_checker #(
    parameter int STACK_DEPTH = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  bqc_pkg::byte_t s_char_in,
    input  logic           s_is_final,
    input  logic           m_valid,
    input  logic           m_ready,
    input  bqc_pkg::byte_t m_char_out,
    input  logic           m_end_of_run,
    input  logic           m_overflowed,
    output int             mismatches,
    output int             in_flight
);
    import bqc_pkg::*;

    typedef struct packed {
        byte_t ch;
        logic  done;
        logic  ovf;
    } out_beat_t;

    localparam byte_t CLOSER_OF [6] = '{CH_RPAREN, CH_RBRACKET, CH_RBRACE,
                                        CH_DQUOTE, CH_BACKQUOTE, CH_APOS};

    out_beat_t due_results[$];
    out_beat_t want;
    code_t     closer_codes[STACK_DEPTH];
    int        open_count;
    bit        in_quote;
    bit        escaped;
    bit        overflow_flag;

    function automatic void expect_beat(input out_beat_t beat);
        due_results = {due_results, beat};
    endfunction

    function automatic byte_t top_closer();
        return (open_count == 0) ? CH_NUL : CLOSER_OF[closer_codes[open_count - 1]];
    endfunction

    function automatic bit push_closer(input code_t code);
        if (open_count >= STACK_DEPTH) begin
            overflow_flag = 1'b1;
            return 1'b0;
        end
        closer_codes[open_count] = code;
        open_count++;
        return 1'b1;
    endfunction

    function automatic void take_char(input byte_t ch);
        byte_t top;
        top = top_closer();
        if (in_quote) begin
            if (escaped) begin
                escaped = 1'b0;
            end else if (ch == CH_BACKSLASH) begin
                escaped = 1'b1;
            end else if (ch == top) begin
                open_count--;
                in_quote = 1'b0;
            end
        end else if (open_count > 0 && ch == top) begin
            open_count--;
        end else begin
            case (ch)
                CH_LPAREN:    void'(push_closer(CODE_PAREN));
                CH_LBRACKET:  void'(push_closer(CODE_BRACKET));
                CH_LBRACE:    void'(push_closer(CODE_BRACE));
                CH_DQUOTE:    in_quote = push_closer(CODE_DQUOTE);
                CH_BACKQUOTE: in_quote = push_closer(CODE_BACKQUOTE);
                CH_APOS:      in_quote = push_closer(CODE_APOS);
                default: ;
            endcase
        end
    endfunction

    function automatic void predict_transaction(input byte_t ch, input logic fin);
        bit    echoed;
        byte_t c;
        echoed = 1'b0;
        if (ch != CH_NUL) begin
            take_char(ch);
            expect_beat(out_beat_t'{ch, logic'(fin && open_count == 0), overflow_flag});
            echoed = 1'b1;
        end
        if (fin) begin
            if (!echoed && open_count == 0) begin
                expect_beat(out_beat_t'{CH_NUL, 1'b1, overflow_flag});
            end
            while (open_count > 0) begin
                c = top_closer();
                open_count--;
                expect_beat(out_beat_t'{c, logic'(open_count == 0), overflow_flag});
            end
            in_quote      = 1'b0;
            escaped       = 1'b0;
            overflow_flag = 1'b0;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            due_results.delete();
            mismatches    = 0;
            open_count    = 0;
            in_quote      = 1'b0;
            escaped       = 1'b0;
            overflow_flag = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("char_out: expected no transaction, actual %h", m_char_out);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    if (m_char_out !== want.ch) begin
                        $error("char_out: expected %h, actual %h", want.ch, m_char_out);
                        mismatches++;
                    end
                    if (m_end_of_run !== want.done) begin
                        $error("end_of_run: expected %b, actual %b", want.done, m_end_of_run);
                        mismatches++;
                    end
                    if (m_overflowed !== want.ovf) begin
                        $error("overflowed: expected %b, actual %b", want.ovf, m_overflowed);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_transaction(s_char_in, s_is_final);
            end
        end
        in_flight = due_results.size();
    end

endmodule

// File: test/bracket_quote_closer_test.sv
// Top of the bracket quote closer testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module bracket_quote_closer_test;
    import bqc_pkg::*;

    localparam int DEPTH       = 32;
    localparam int ITEM_GOAL   = 430;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 150;

    logic  aclk       = 1'b0;
    logic  aresetn    = 1'b0;
    logic  s_valid    = 1'b0;
    logic  s_ready;
    byte_t s_char_in  = CH_NUL;
    logic  s_is_final = 1'b0;
    logic  m_valid;
    logic  m_ready    = 1'b0;
    byte_t m_char_out;
    logic  m_end_of_run;
    logic  m_overflowed;

    int mismatches;
    int in_flight;
    int items_sent = 0;
    int expr_count = 0;
    int deep_count = 0;
    int idle_cycles = 0;

    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  phase_cnt = 0;
    bit  free_run = 1'b0;
    int  ready_roll;

    always #6 aclk = ~aclk;

    bracket_quote_closer #(
        .STACK_DEPTH(DEPTH)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_in   (s_char_in),
        .s_is_final  (s_is_final),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_out  (m_char_out),
        .m_end_of_run(m_end_of_run),
        .m_overflowed(m_overflowed)
    );

    bracket_quote_closer_checker #(
        .STACK_DEPTH(DEPTH)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_in   (s_char_in),
        .s_is_final  (s_is_final),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_out  (m_char_out),
        .m_end_of_run(m_end_of_run),
        .m_overflowed(m_overflowed),
        .mismatches  (mismatches),
        .in_flight   (in_flight)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic byte_t pick_opener();
        int k;
        k = $urandom_range(0, 2);
        return (k == 0) ? CH_LPAREN : (k == 1) ? CH_LBRACKET : CH_LBRACE;
    endfunction

    function automatic byte_t pick_quote();
        int k;
        k = $urandom_range(0, 2);
        return (k == 0) ? CH_DQUOTE : (k == 1) ? CH_BACKQUOTE : CH_APOS;
    endfunction

    function automatic byte_t pick_char();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 14) return pick_opener();
        if (r < 30) begin
            k = $urandom_range(0, 2);
            return (k == 0) ? CH_RPAREN : (k == 1) ? CH_RBRACKET : CH_RBRACE;
        end
        if (r < 42) return pick_quote();
        if (r < 50) return CH_BACKSLASH;
        if (r < 53) return CH_NUL;
        if (r < 80) return byte_t'($urandom_range(8'h61, 8'h7A));
        return byte_t'($urandom_range(1, 255));
    endfunction

    task automatic send_byte(input byte_t ch, input logic fin, input bit burst);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_char_in  <= ch;
        s_is_final <= fin;
        do @(posedge aclk); while (!s_ready);
        if (ch != CH_NUL || fin) items_sent++;
    endtask

    task automatic send_expression();
        int len;
        bit burst;
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 28) : $urandom_range(1, 10);
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len - 1; i++) send_byte(pick_char(), 1'b0, burst);
        send_byte(pick_char(), 1'b1, burst);
    endtask

    // Exact depth with a plain final byte gives the longest unwind.
    task automatic send_deep(input int opens, input bit exact);
        for (int i = 0; i < opens; i++) send_byte(pick_opener(), 1'b0, 1'b0);
        if (exact) begin
            send_byte(byte_t'(8'h61), 1'b1, 1'b0);
        end else begin
            send_byte(pick_quote(), 1'b0, 1'b0);
            repeat ($urandom_range(1, 3)) send_byte(pick_char(), 1'b0, 1'b0);
            send_byte(pick_char(), 1'b1, 1'b0);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            phase_cnt++;
            if (phase_cnt == 150) begin
                phase_cnt = 0;
                free_run  = ($urandom_range(0, 3) == 0);
            end
            if (!hold_done && items_sent >= 120) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (free_run) begin
                m_ready <= 1'b1;
            end else begin
                ready_roll = $urandom_range(0, 99);
                if (ready_roll < 65) begin
                    m_ready <= 1'b1;
                end else begin
                    stall_left = (ready_roll < 92) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                    m_ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("bracket_quote_closer_test NOT OK");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // nested openers closed by a zero final byte
        send_byte(CH_LPAREN, 1'b0, 1'b0);
        send_byte(CH_LBRACKET, 1'b0, 1'b0);
        send_byte(CH_LBRACE, 1'b0, 1'b0);
        send_byte(CH_NUL, 1'b1, 1'b0);
        // escapes, quote kinds, closing quote that must not reopen
        send_byte(CH_DQUOTE, 1'b0, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0, 1'b0);
        send_byte(CH_DQUOTE, 1'b0, 1'b0);
        send_byte(CH_NUL, 1'b0, 1'b0);
        send_byte(CH_DQUOTE, 1'b0, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0, 1'b0);
        send_byte(CH_BACKQUOTE, 1'b0, 1'b0);
        send_byte(CH_BACKQUOTE, 1'b0, 1'b0);
        send_byte(CH_APOS, 1'b0, 1'b0);
        send_byte(byte_t'(8'h7A), 1'b1, 1'b0);
        // stray and mismatched closers
        send_byte(CH_RPAREN, 1'b0, 1'b0);
        send_byte(CH_LPAREN, 1'b0, 1'b0);
        send_byte(CH_RBRACKET, 1'b0, 1'b0);
        send_byte(CH_RPAREN, 1'b1, 1'b0);
        // byte extremes and an empty expression
        send_byte(byte_t'(8'hFF), 1'b1, 1'b0);
        send_byte(CH_NUL, 1'b1, 1'b0);
        send_byte(byte_t'(8'h80), 1'b0, 1'b0);
        send_byte(CH_LBRACE, 1'b0, 1'b0);
        send_byte(byte_t'(8'h7F), 1'b1, 1'b0);

        while (items_sent < ITEM_GOAL) begin
            if (expr_count % 16 == 5) begin
                if (deep_count == 0) send_deep(DEPTH, 1'b1);
                else send_deep($urandom_range(DEPTH - 2, DEPTH + 4), 1'b0);
                deep_count++;
            end else begin
                send_expression();
            end
            expr_count++;
        end
        s_valid <= 1'b0;

        do @(negedge aclk); while (in_flight != 0);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("bracket_quote_closer_test OK");
        end else begin
            $display("bracket_quote_closer_test NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/bqc_pkg.sv
rtl/bqc_ctrl.sv
rtl/bqc_dp.sv
rtl/bracket_quote_closer.sv
test/bracket_quote_closer_checker.sv
test/bracket_quote_closer_test.sv
